@@ design/zrld_pkg.sv @@
// ----------------------------------------------------------------------------
// zrld_pkg
// shared types and constants for the zero run length decoder
// ----------------------------------------------------------------------------
package zrld_pkg;

	localparam int FRAGMENT_BYTES_DEF = 8;
	localparam int COUNT_BITS_DEF     = 24;
	localparam int TOTAL_W            = 24;
	localparam int CODE_W             = 8;
	localparam int NBYTES_W           = 4;
	localparam int RUN_W              = 8;
	localparam int MAX_RESULTS        = 16;

	localparam logic [CODE_W-1:0] HDR_LITERAL = 8'h80;

	typedef enum logic [1:0] {
		MODE_HEADER   = 2'd0,
		MODE_LITERAL  = 2'd1,
		MODE_ZERO_LIT = 2'd2
	} mode_t;

	// one decoded run handed to the fragment stage
	typedef struct packed {
		logic              has_out;
		logic [CODE_W-1:0] data;
		logic [RUN_W-1:0]  cnt;
		logic              over;
		logic              done;
	} run_t;

endpackage

@@ design/zrld_decode.sv @@
// ----------------------------------------------------------------------------
// zrld_decode
// decode state and next-state logic for one coded byte per step
// ----------------------------------------------------------------------------
module zrld_decode #(
	parameter int FRAGMENT_BYTES = zrld_pkg::FRAGMENT_BYTES_DEF,
	parameter int COUNT_BITS     = zrld_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [zrld_pkg::CODE_W-1:0]    code_byte,
	input  logic                           stream_start,
	input  logic [zrld_pkg::TOTAL_W-1:0]   total,
	output zrld_pkg::run_t                 run
);

	localparam int TW  = (COUNT_BITS > zrld_pkg::TOTAL_W) ? COUNT_BITS : zrld_pkg::TOTAL_W;
	localparam int CAP = zrld_pkg::MAX_RESULTS * FRAGMENT_BYTES;
	localparam logic [zrld_pkg::RUN_W-1:0] CAP_V = zrld_pkg::RUN_W'(CAP);

	zrld_pkg::mode_t         mode_q, mode_e, mode_n;
	logic [6:0]              lit_q, lit_e, lit_n;
	logic [COUNT_BITS-1:0]   bw_q, bw_e, bw_n;
	logic                    fin_q, fin_e, fin_n;

	logic [TW-1:0]           total_ext;
	logic [TW-1:0]           cmax_ext;
	logic [COUNT_BITS-1:0]   tot;
	logic [COUNT_BITS-1:0]   rem;
	logic [COUNT_BITS-1:0]   n_ext;
	logic [COUNT_BITS-1:0]   take_c;
	logic [zrld_pkg::RUN_W-1:0] take8;
	logic [zrld_pkg::RUN_W-1:0] take;
	logic                    zover;

	assign total_ext = TW'(total);
	assign cmax_ext  = TW'({COUNT_BITS{1'b1}});
	assign tot       = (total_ext > cmax_ext) ? cmax_ext[COUNT_BITS-1:0]
	                                          : total_ext[COUNT_BITS-1:0];

	// a new stream clears everything before its first byte is decoded
	assign mode_e = stream_start ? zrld_pkg::MODE_HEADER : mode_q;
	assign lit_e  = stream_start ? 7'd0 : lit_q;
	assign bw_e   = stream_start ? '0 : bw_q;
	assign fin_e  = stream_start ? 1'b0 : fin_q;

	// zero run sizing
	assign rem    = tot - bw_e;
	assign n_ext  = COUNT_BITS'(code_byte[6:0]);
	assign zover  = ((n_ext + COUNT_BITS'(1)) > rem)
	             || ({1'b0, code_byte[6:0]} > CAP_V);
	assign take_c = (n_ext > rem) ? rem : n_ext;
	assign take8  = zrld_pkg::RUN_W'(take_c);
	assign take   = (take8 > CAP_V) ? CAP_V : take8;

	always_comb begin
		mode_n = mode_e;
		lit_n  = lit_e;
		bw_n   = bw_e;
		fin_n  = fin_e;
		run    = '0;
		if (fin_e || (bw_e >= tot)) begin
			fin_n = 1'b1;
		end else begin
			unique case (mode_e)
				zrld_pkg::MODE_LITERAL, zrld_pkg::MODE_ZERO_LIT: begin
					bw_n = bw_e + COUNT_BITS'(1);
					if (mode_e == zrld_pkg::MODE_LITERAL) begin
						lit_n  = lit_e - 7'd1;
						mode_n = (lit_n != 7'd0) ? zrld_pkg::MODE_LITERAL
						                         : zrld_pkg::MODE_HEADER;
					end else begin
						mode_n = zrld_pkg::MODE_HEADER;
					end
					run.has_out = 1'b1;
					run.data    = code_byte;
					run.cnt     = zrld_pkg::RUN_W'(1);
					if (bw_n == tot) begin
						fin_n    = 1'b1;
						run.over = (lit_n != 7'd0);
					end
					run.done = fin_n;
				end
				default: begin
					if ((code_byte & zrld_pkg::HDR_LITERAL) != '0) begin
						// literal run header, all ones is an empty run
						if (~code_byte[6:0] != 7'd0) begin
							lit_n  = ~code_byte[6:0];
							mode_n = zrld_pkg::MODE_LITERAL;
						end
					end else begin
						mode_n      = zrld_pkg::MODE_ZERO_LIT;
						bw_n        = bw_e + COUNT_BITS'(take);
						fin_n       = (bw_n >= tot);
						run.has_out = (take != '0);
						run.cnt     = take;
						run.over    = zover;
						run.done    = fin_n;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= zrld_pkg::MODE_HEADER;
			lit_q  <= 7'd0;
			bw_q   <= '0;
			fin_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			lit_q  <= lit_n;
			bw_q   <= bw_n;
			fin_q  <= fin_n;
		end
	end

endmodule

@@ design/zero_run_length_decoder_top.sv @@
// ----------------------------------------------------------------------------
// zero_run_length_decoder_top
// run-length coded byte stream to decoded byte fragments
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) takes one coded byte per transfer with
// stream_start marking the first byte of a stream. cfg_we writes total_bytes,
// the decoded length of the stream; the user writes it only while the block
// is idle; the block does not enforce it. output channel (out_valid/out_ready)
// carries fragments of up to FRAGMENT_BYTES bytes, lowest byte first, with
// run_last, stream_complete and overrun flags.
// a coded byte is registered in the input register and then decoded into the
// fragment register, from which its first fragment is presented.
// one coded byte per cycle for headers, and for literals while the receiver
// takes each fragment; a zero run of n bytes holds the single fragment register
// for ceil(n / FRAGMENT_BYTES) transfers, and bytes that make a fragment wait.
// reset clears the decode state, the byte count and total_bytes; no fragments
// are pending afterward. when the receiver stalls, the pending fragment holds,
// bytes that make no fragment still pass, and in_ready drops once a byte that
// makes a fragment waits in the input register.
// ----------------------------------------------------------------------------
module zero_run_length_decoder_top #(
	parameter int FRAGMENT_BYTES = zrld_pkg::FRAGMENT_BYTES_DEF,
	parameter int COUNT_BITS     = zrld_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [zrld_pkg::TOTAL_W-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [zrld_pkg::CODE_W-1:0]     code_byte,
	input  logic                            stream_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [FRAGMENT_BYTES*8-1:0]     fragment_data,
	output logic [zrld_pkg::NBYTES_W-1:0]   fragment_bytes,
	output logic                            run_last,
	output logic                            stream_complete,
	output logic                            overrun
);

	localparam logic [zrld_pkg::RUN_W-1:0] FB_V = zrld_pkg::RUN_W'(FRAGMENT_BYTES);

	logic [zrld_pkg::TOTAL_W-1:0] total_q;

	logic                         valid_s1;
	logic [zrld_pkg::CODE_W-1:0]  code_s1;
	logic                         start_s1;

	logic                         valid_s2;
	logic [zrld_pkg::CODE_W-1:0]  data_s2;
	logic [zrld_pkg::RUN_W-1:0]   cnt_s2;
	logic                         over_s2;
	logic                         done_s2;

	zrld_pkg::run_t               run;
	logic                         s2_last;
	logic                         s2_free;
	logic                         step;

	zrld_decode #(
		.FRAGMENT_BYTES (FRAGMENT_BYTES),
		.COUNT_BITS     (COUNT_BITS)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.code_byte    (code_s1),
		.stream_start (start_s1),
		.total        (total_q),
		.run          (run)
	);

	assign s2_last  = (cnt_s2 <= FB_V);
	assign s2_free  = !valid_s2 || (out_ready && s2_last);
	assign step     = valid_s1 && (s2_free || !run.has_out);
	assign in_ready = !valid_s1 || step;

	assign out_valid       = valid_s2;
	assign fragment_data   = (FRAGMENT_BYTES*8)'(data_s2);
	assign fragment_bytes  = s2_last ? zrld_pkg::NBYTES_W'(cnt_s2)
	                                 : zrld_pkg::NBYTES_W'(FRAGMENT_BYTES);
	assign run_last        = s2_last;
	assign stream_complete = s2_last && done_s2;
	assign overrun         = over_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1  <= code_byte;
			start_s1 <= stream_start;
		end
	end

	// fragment register, a zero run counts down one fragment per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && run.has_out) begin
			valid_s2 <= 1'b1;
		end else if (valid_s2 && out_ready && s2_last) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && run.has_out) begin
			data_s2 <= run.data;
			cnt_s2  <= run.cnt;
			over_s2 <= run.over;
			done_s2 <= run.done;
		end else if (valid_s2 && out_ready && !s2_last) begin
			cnt_s2 <= cnt_s2 - FB_V;
		end
	end

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != '0))
		else $error("pending fragment with zero byte count");

	a_literal_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (data_s2 != '0)) |-> (cnt_s2 == zrld_pkg::RUN_W'(1)))
		else $error("literal byte spans more than one byte");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_last) |=> (out_valid && $stable(overrun)))
		else $error("zero run ended before its last fragment");

	a_no_step_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(step && run.has_out) |-> s2_free)
		else $error("decoded run overwrote a pending fragment");

endmodule

@@ dv/zero_run_length_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// zero_run_length_decoder_top_test
// self-checking bench for the zero run length decoder
// ----------------------------------------------------------------------------
// a table of directed coded bytes and total_bytes writes covers the header
// kinds, empty runs, clipping at the total and the full sixteen fragment run.
// random phases follow, each with its own total and mostly well-formed
// streams with some noise and restarts. every transfer in is decoded by a
// predictor in the bench, and each fragment out is compared field by field
// with the oldest expected fragment. both channels get random gaps, and the
// receiver holds off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module zero_run_length_decoder_top_test;

	localparam int FRAG_BYTES = zrld_pkg::FRAGMENT_BYTES_DEF;
	localparam int ZERO_CAP = zrld_pkg::MAX_RESULTS * FRAG_BYTES;
	localparam int RANDOM_ITEMS = 400;
	localparam int SETTLE_CYCLES = 24;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int unsigned TIMEOUT_CYCLES = 400000;

	typedef struct packed {
		logic [FRAG_BYTES*8-1:0]           data;
		logic [zrld_pkg::NBYTES_W-1:0]     nbytes;
		logic                              last;
		logic                              done;
		logic                              over;
	} frag_t;

	typedef struct packed {
		logic                         is_cfg;
		logic [zrld_pkg::TOTAL_W-1:0] value;
		logic                         start;
		logic                         typed;
		logic                         has_frag;
		frag_t                        frag;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [zrld_pkg::TOTAL_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [zrld_pkg::CODE_W-1:0] code_byte;
	logic stream_start;
	logic out_valid;
	logic out_ready;
	logic [FRAG_BYTES*8-1:0] fragment_data;
	logic [zrld_pkg::NBYTES_W-1:0] fragment_bytes;
	logic run_last;
	logic stream_complete;
	logic overrun;

	// decoder state mirrored by the predictor
	int unsigned total_cfg = 0;
	zrld_pkg::mode_t dec_mode = zrld_pkg::MODE_HEADER;
	logic [6:0] lit_left = '0;
	int unsigned out_count = 0;
	logic stream_done = 1'b0;
	frag_t step_frags[zrld_pkg::MAX_RESULTS];

	frag_t frag_q[$];
	stim_row_t dir_rows[$];
	int fail_count = 0;
	int live_items = 0;
	bit no_idle = 1'b0;
	bit rx_hold_req = 1'b0;
	bit pin_on = 1'b0;
	bit pin_cnt = 1'b0;
	frag_t pin_frag;
	logic next_start;

	zero_run_length_decoder_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.code_byte       (code_byte),
		.stream_start    (stream_start),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.fragment_data   (fragment_data),
		.fragment_bytes  (fragment_bytes),
		.run_last        (run_last),
		.stream_complete (stream_complete),
		.overrun         (overrun)
	);

	always #10 clk = ~clk;

	function automatic int decode_code(input logic [zrld_pkg::CODE_W-1:0] code,
		input logic start);
		int unsigned rem;
		int unsigned take;
		int unsigned sz;
		logic over;
		int n;
		n = 0;
		if (start) begin
			dec_mode = zrld_pkg::MODE_HEADER;
			lit_left = '0;
			out_count = 0;
			stream_done = 1'b0;
		end
		if (stream_done || out_count >= total_cfg) begin
			stream_done = 1'b1;
			return 0;
		end
		rem = total_cfg - out_count;
		if (dec_mode == zrld_pkg::MODE_LITERAL || dec_mode == zrld_pkg::MODE_ZERO_LIT) begin
			out_count++;
			if (dec_mode == zrld_pkg::MODE_LITERAL) begin
				lit_left = lit_left - 7'd1;
				dec_mode = (lit_left != 0) ? zrld_pkg::MODE_LITERAL : zrld_pkg::MODE_HEADER;
			end else begin
				dec_mode = zrld_pkg::MODE_HEADER;
			end
			over = 1'b0;
			if (out_count == total_cfg) begin
				stream_done = 1'b1;
				over = (lit_left != 0);
			end
			step_frags[0] = '{data: 64'(code), nbytes: 4'd1, last: 1'b1,
				done: stream_done, over: over};
			return 1;
		end
		if ((code & zrld_pkg::HDR_LITERAL) != 0) begin
			if ((~code[6:0]) != 7'd0) begin
				lit_left = ~code[6:0];
				dec_mode = zrld_pkg::MODE_LITERAL;
			end
			return 0;
		end
		// zero run, clipped at the total and at the fragment capacity
		take = code;
		over = (int'(code) + 1 > rem) || (int'(code) > ZERO_CAP);
		if (take > rem)
			take = rem;
		if (take > ZERO_CAP)
			take = ZERO_CAP;
		dec_mode = zrld_pkg::MODE_ZERO_LIT;
		while (take > 0 && n < zrld_pkg::MAX_RESULTS) begin
			sz = (take > FRAG_BYTES) ? FRAG_BYTES : take;
			take -= sz;
			out_count += sz;
			if (out_count >= total_cfg)
				stream_done = 1'b1;
			step_frags[n] = '{data: '0, nbytes: 4'(sz), last: (take == 0),
				done: (take == 0) && stream_done, over: over};
			n++;
		end
		return n;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		fail_count++;
		if (fail_count <= 50)
			$display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : monitor_p
		int n;
		frag_t want;
		if (arst_n) begin
			if (cfg_we)
				total_cfg = 32'(cfg_wdata);
			if (in_valid && in_ready) begin
				n = decode_code(code_byte, stream_start);
				if (pin_on) begin
					n = pin_cnt;
					step_frags[0] = pin_frag;
					pin_on = 1'b0;
				end
				for (int i = 0; i < n; i++)
					frag_q.push_back(step_frags[i]);
			end
			if (out_valid && out_ready) begin
				if (frag_q.size() == 0) begin
					report_mismatch("unexpected fragment", fragment_data, '0);
				end else begin
					want = frag_q.pop_front();
					if (fragment_data !== want.data)
						report_mismatch("fragment_data", fragment_data, want.data);
					if (fragment_bytes !== want.nbytes)
						report_mismatch("fragment_bytes", 64'(fragment_bytes), 64'(want.nbytes));
					if (run_last !== want.last)
						report_mismatch("run_last", 64'(run_last), 64'(want.last));
					if (stream_complete !== want.done)
						report_mismatch("stream_complete", 64'(stream_complete), 64'(want.done));
					if (overrun !== want.over)
						report_mismatch("overrun", 64'(overrun), 64'(want.over));
				end
			end
		end
	end

	// receiver: random stalls per transfer, one long hold-off on request
	initial begin : receiver_p
		int unsigned stall_cyc;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else begin
				stall_cyc = no_idle ? 0 : $urandom_range(0, 4);
				if (stall_cyc != 0) begin
					out_ready <= 1'b0;
					repeat (stall_cyc) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_code(input logic [zrld_pkg::CODE_W-1:0] code, input logic start);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (!stream_done || start)
			live_items++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= code;
		stream_start <= start;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	task automatic emit(input logic [zrld_pkg::CODE_W-1:0] code);
		send_code(code, next_start);
		next_start = 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (frag_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_total(input logic [zrld_pkg::TOTAL_W-1:0] value);
		wait_idle();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic stim_row_t cfg_row(input logic [zrld_pkg::TOTAL_W-1:0] value);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.value = value;
		return r;
	endfunction

	function automatic stim_row_t code_row(input logic [zrld_pkg::CODE_W-1:0] code,
		input logic start);
		stim_row_t r;
		r = '0;
		r.value = zrld_pkg::TOTAL_W'(code);
		r.start = start;
		return r;
	endfunction

	// no fragment expected
	function automatic stim_row_t quiet_row(input logic [zrld_pkg::CODE_W-1:0] code,
		input logic start);
		stim_row_t r;
		r = code_row(code, start);
		r.typed = 1'b1;
		return r;
	endfunction

	// exactly one fragment, given here
	function automatic stim_row_t lone_row(input logic [zrld_pkg::CODE_W-1:0] code,
		input logic start, input logic [63:0] data,
		input logic [zrld_pkg::NBYTES_W-1:0] nbytes, input logic done, input logic over);
		stim_row_t r;
		r = code_row(code, start);
		r.typed = 1'b1;
		r.has_frag = 1'b1;
		r.frag = '{data: data, nbytes: nbytes, last: 1'b1, done: done, over: over};
		return r;
	endfunction

	initial begin : stimulus_p
		int unsigned pick;
		int unsigned run;
		int unsigned spent;
		logic [zrld_pkg::TOTAL_W-1:0] tot;
		bit first_phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		code_byte = '0;
		stream_start = 1'b0;
		next_start = 1'b0;
		pin_frag = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// total of zero after reset
		dir_rows.push_back(quiet_row(8'h05, 1'b1));
		dir_rows.push_back(cfg_row(24'd40));
		dir_rows.push_back(quiet_row(8'hFE, 1'b1));
		dir_rows.push_back(lone_row(8'hAB, 1'b0, 64'hAB, 4'd1, 1'b0, 1'b0));
		// empty literal run, then empty zero run
		dir_rows.push_back(quiet_row(8'hFF, 1'b0));
		dir_rows.push_back(quiet_row(8'h00, 1'b0));
		dir_rows.push_back(lone_row(8'h5A, 1'b0, 64'h5A, 4'd1, 1'b0, 1'b0));
		dir_rows.push_back(code_row(8'h0B, 1'b0));
		dir_rows.push_back(code_row(8'h00, 1'b0));
		dir_rows.push_back(quiet_row(8'hFC, 1'b0));
		dir_rows.push_back(code_row(8'hFF, 1'b0));
		dir_rows.push_back(code_row(8'h80, 1'b0));
		dir_rows.push_back(code_row(8'h7F, 1'b0));
		// zero run clipped at the total, then ignored
		dir_rows.push_back(code_row(8'h7F, 1'b0));
		dir_rows.push_back(quiet_row(8'h33, 1'b0));
		dir_rows.push_back(cfg_row(24'hFFFFFF));
		dir_rows.push_back(code_row(8'h7F, 1'b1));
		dir_rows.push_back(code_row(8'h80, 1'b0));
		dir_rows.push_back(code_row(8'h01, 1'b1));
		dir_rows.push_back(code_row(8'hC3, 1'b0));
		// literal run cut short by the total
		dir_rows.push_back(cfg_row(24'd1));
		dir_rows.push_back(quiet_row(8'hFD, 1'b1));
		dir_rows.push_back(lone_row(8'h11, 1'b0, 64'h11, 4'd1, 1'b1, 1'b1));
		dir_rows.push_back(quiet_row(8'h22, 1'b0));
		// zeros land exactly on the total
		dir_rows.push_back(cfg_row(24'd3));
		dir_rows.push_back(lone_row(8'h03, 1'b1, 64'h0, 4'd3, 1'b1, 1'b1));
		dir_rows.push_back(quiet_row(8'h44, 1'b0));

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				write_total(dir_rows[k].value);
			end else begin
				pin_on = dir_rows[k].typed;
				pin_cnt = dir_rows[k].has_frag;
				pin_frag = dir_rows[k].frag;
				send_code(dir_rows[k].value[zrld_pkg::CODE_W-1:0], dir_rows[k].start);
			end
		end

		live_items = 0;
		first_phase = 1'b1;
		while (live_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (first_phase)
				tot = 24'd400;
			else if (pick == 0)
				tot = '0;
			else if (pick == 1)
				tot = 24'hFFFFFF;
			else if (pick <= 3)
				tot = zrld_pkg::TOTAL_W'($urandom_range(1, 16));
			else
				tot = zrld_pkg::TOTAL_W'($urandom_range(17, 400));
			write_total(tot);
			no_idle = !first_phase && ($urandom_range(0, 3) == 0);
			next_start = first_phase || ($urandom_range(0, 4) != 0);
			if (first_phase)
				rx_hold_req = 1'b1;
			first_phase = 1'b0;
			spent = live_items + $urandom_range(15, 60);
			while ((next_start || !stream_done) && live_items < spent) begin
				pick = $urandom_range(0, 19);
				if (pick < 8) begin
					run = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
					                                  : $urandom_range(1, 6);
					emit({1'b1, ~run[6:0]});
					repeat (run)
						if (!stream_done)
							emit(zrld_pkg::CODE_W'($urandom_range(0, 255)));
				end else if (pick < 16) begin
					run = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
					                                  : $urandom_range(0, 20);
					emit(zrld_pkg::CODE_W'(run));
					if (!stream_done)
						emit(zrld_pkg::CODE_W'($urandom_range(0, 255)));
				end else if (pick == 16) begin
					emit(8'hFF);
				end else if (pick == 17) begin
					// restart in the middle of a stream
					next_start = 1'b1;
					emit(zrld_pkg::CODE_W'($urandom_range(0, 255)));
				end else begin
					emit(zrld_pkg::CODE_W'($urandom_range(0, 255)));
				end
			end
			repeat ($urandom_range(0, 3))
				emit(zrld_pkg::CODE_W'($urandom_range(0, 255)));
		end

		wait_idle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog_p
		#(64'd20 * TIMEOUT_CYCLES);
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
design/zrld_pkg.sv
design/zrld_decode.sv
design/zero_run_length_decoder_top.sv
dv/zero_run_length_decoder_top_test.sv
